FILE: rtl/ezss_pkg.sv
// ----------------------------------------------------------------------------
// ezss_pkg
// Shared types, widths and codes of the energy / zero-crossing segmenter.
// ----------------------------------------------------------------------------
package ezss_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int MAX_CHUNK_DEF   = 4096;

	localparam int ENERGY_W    = 43;
	localparam int CROSS_W     = 13;
	localparam int SEG_W       = 16;
	localparam int HELD_W      = 4;
	localparam int ACT_W       = 4;
	localparam int LEN_W       = 13;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 43;
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_W       = 88;

	localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
	localparam logic [CROSS_W-1:0]  CROSS_MAX  = '1;
	localparam logic [SEG_W-1:0]    SEG_MAX    = '1;

	localparam logic [ACT_W-1:0] ACT_CLEAR   = 4'd0;
	localparam logic [ACT_W-1:0] ACT_ADD     = 4'd1;
	localparam logic [ACT_W-1:0] ACT_REPLACE = 4'd2;
	localparam logic [ACT_W-1:0] ACT_START   = 4'd3;
	localparam logic [ACT_W-1:0] ACT_EXTEND  = 4'd4;
	localparam logic [ACT_W-1:0] ACT_END_MAX = 4'd5;
	localparam logic [ACT_W-1:0] ACT_HANG    = 4'd6;
	localparam logic [ACT_W-1:0] ACT_END     = 4'd7;
	localparam logic [ACT_W-1:0] ACT_CANCEL  = 4'd8;

	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LENGTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_LOW     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_HIGH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CROSSINGS_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CROSSINGS_HIGH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PREROLL_MAX    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_MIN    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_MAX    = 3'd7;

	localparam logic [1:0] SIGN_NONE = 2'd0;
	localparam logic [1:0] SIGN_POS  = 2'd1;
	localparam logic [1:0] SIGN_NEG  = 2'd2;

	typedef struct packed {
		logic [LEN_W-1:0]    chunk_length;
		logic [ENERGY_W-1:0] energy_low;
		logic [ENERGY_W-1:0] energy_high;
		logic [CROSS_W-1:0]  crossings_low;
		logic [CROSS_W-1:0]  crossings_high;
		logic [HELD_W-1:0]   preroll_max;
		logic [SEG_W-1:0]    segment_min;
		logic [SEG_W-1:0]    segment_max;
	} cfg_t;

	typedef struct packed {
		logic [ENERGY_W-1:0] energy;
		logic [CROSS_W-1:0]  crossings;
	} chunk_t;

	typedef struct packed {
		logic [HELD_W-1:0]   preroll_count;
		logic                sound_active;
		logic [SEG_W-1:0]    segment_length;
		logic [CROSS_W-1:0]  chunk_crossings;
		logic [ENERGY_W-1:0] chunk_energy;
		logic [ACT_W-1:0]    action;
	} result_t;

endpackage

FILE: rtl/ezss_front.sv
// ----------------------------------------------------------------------------
// ezss_front
// Frame intake: peak, sign changes, squared peak and per-chunk energy sum.
// ----------------------------------------------------------------------------
module ezss_front import ezss_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_CHUNK   = MAX_CHUNK_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] first_sample,
	input  logic [SAMPLE_BITS-1:0] rest_peak,
	input  logic [LEN_W-1:0]       chunk_length,
	input  logic                   queue_full,
	output logic                   push,
	output chunk_t                 push_data
);

	localparam int IDX_W = $clog2(MAX_CHUNK);
	localparam int CW    = IDX_W + 1;
	localparam int LW    = (LEN_W > CW) ? LEN_W : CW;
	localparam int SQ_W  = 2 * SAMPLE_BITS;
	localparam int SUM_W = ((SQ_W > ENERGY_W) ? SQ_W : ENERGY_W) + 1;
	localparam logic [LW-1:0] MAXC = LW'(MAX_CHUNK);

	logic [LW-1:0]          len_ext;
	logic [LW-1:0]          len_eff;
	logic [CW-1:0]          frame_next;
	logic                   chunk_end;
	logic                   neg;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SAMPLE_BITS-1:0] peak;
	logic [1:0]             sign_now;
	logic [CROSS_W-1:0]     cross_new;
	logic [1:0]             sign_new;
	logic                   accept;
	logic                   advance;
	logic [SUM_W-1:0]       sum_wide;
	logic [ENERGY_W-1:0]    sum_sat;

	logic [IDX_W-1:0]       frame_q;
	logic [CROSS_W-1:0]     cross_q;
	logic [1:0]             sign_q;
	logic [ENERGY_W-1:0]    energy_q;

	logic                   valid_s1;
	logic                   last_s1;
	logic [SAMPLE_BITS-1:0] peak_s1;
	logic [CROSS_W-1:0]     z_s1;
	logic                   valid_s2;
	logic                   last_s2;
	logic [SQ_W-1:0]        sq_s2;
	logic [CROSS_W-1:0]     z_s2;

	always_comb begin
		len_ext = LW'(chunk_length);
		if (len_ext == '0) begin
			len_eff = LW'(1);
		end else if (len_ext > MAXC) begin
			len_eff = MAXC;
		end else begin
			len_eff = len_ext;
		end
	end

	assign frame_next = CW'(frame_q) + CW'(1);
	assign chunk_end  = LW'(frame_next) >= len_eff;

	assign neg      = first_sample[SAMPLE_BITS-1];
	assign mag      = neg ? (~first_sample + SAMPLE_BITS'(1)) : first_sample;
	assign peak     = (rest_peak > mag) ? rest_peak : mag;
	assign sign_now = neg ? SIGN_NEG : SIGN_POS;

	always_comb begin
		cross_new = cross_q;
		sign_new  = sign_q;
		if (peak != '0) begin
			if (sign_q != SIGN_NONE && sign_q != sign_now && cross_q != CROSS_MAX) begin
				cross_new = cross_q + CROSS_W'(1);
			end
			sign_new = sign_now;
		end
	end

	assign advance  = !(valid_s2 && last_s2 && queue_full);
	assign in_ready = advance;
	assign accept   = in_valid && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			cross_q <= '0;
			sign_q  <= SIGN_NONE;
		end else if (accept) begin
			if (chunk_end) begin
				frame_q <= '0;
				cross_q <= '0;
				sign_q  <= SIGN_NONE;
			end else begin
				frame_q <= frame_next[IDX_W-1:0];
				cross_q <= cross_new;
				sign_q  <= sign_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			peak_s1 <= peak;
			last_s1 <= chunk_end;
			z_s1    <= cross_new;
		end
		if (advance) begin
			sq_s2   <= SQ_W'(peak_s1) * SQ_W'(peak_s1);
			last_s2 <= last_s1;
			z_s2    <= z_s1;
		end
	end

	assign sum_wide = SUM_W'(energy_q) + SUM_W'(sq_s2);
	assign sum_sat  = (sum_wide > SUM_W'(ENERGY_MAX)) ? ENERGY_MAX : sum_wide[ENERGY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
		end else if (advance && valid_s2) begin
			energy_q <= last_s2 ? '0 : sum_sat;
		end
	end

	assign push                = advance && valid_s2 && last_s2;
	assign push_data.energy    = sum_sat;
	assign push_data.crossings = z_s2;

endmodule

FILE: rtl/ezss_queue.sv
// ----------------------------------------------------------------------------
// ezss_queue
// Short queue of finished chunk sums between intake and decision logic.
// ----------------------------------------------------------------------------
module ezss_queue import ezss_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  chunk_t push_data,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output chunk_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	chunk_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full       = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

FILE: rtl/ezss_back.sv
// ----------------------------------------------------------------------------
// ezss_back
// Silent/sound decision per chunk with pre-roll, hangover and segment count.
// ----------------------------------------------------------------------------
module ezss_back import ezss_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    chunk_valid,
	input  chunk_t  chunk,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t result
);

	logic              in_sound_q;
	logic [HELD_W-1:0] held_q;
	logic [SEG_W-1:0]  seg_q;
	logic              out_valid_q;
	result_t           res_q;

	logic              in_sound_d;
	logic [HELD_W-1:0] held_d;
	logic [SEG_W-1:0]  seg_d;
	result_t           res_d;

	always_comb begin
		logic              loud;
		logic              active;
		logic [SEG_W:0]    ext_wide;
		logic [SEG_W-1:0]  seg_ext;
		logic [SEG_W-1:0]  seg_out;
		logic [ACT_W-1:0]  act;

		loud     = chunk.energy > cfg.energy_high || chunk.crossings > cfg.crossings_high;
		active   = chunk.energy > cfg.energy_low || chunk.crossings > cfg.crossings_low;
		ext_wide = (SEG_W+1)'(seg_q) + (SEG_W+1)'(held_q) + (SEG_W+1)'(1);
		seg_ext  = ext_wide[SEG_W] ? SEG_MAX : ext_wide[SEG_W-1:0];

		in_sound_d = in_sound_q;
		held_d     = held_q;
		seg_d      = seg_q;
		seg_out    = '0;
		act        = ACT_CLEAR;

		if (!in_sound_q) begin
			if (loud) begin
				seg_d      = SEG_W'(held_q) + SEG_W'(1);
				seg_out    = SEG_W'(held_q) + SEG_W'(1);
				held_d     = '0;
				in_sound_d = 1'b1;
				act        = ACT_START;
			end else if (active) begin
				if (held_q < cfg.preroll_max) begin
					held_d = held_q + HELD_W'(1);
					act    = ACT_ADD;
				end else begin
					act = ACT_REPLACE;
				end
			end else begin
				held_d = '0;
				act    = ACT_CLEAR;
			end
		end else begin
			if (active) begin
				held_d  = '0;
				seg_out = seg_ext;
				if (seg_ext >= cfg.segment_max) begin
					act        = ACT_END_MAX;
					in_sound_d = 1'b0;
					seg_d      = '0;
				end else begin
					act   = ACT_EXTEND;
					seg_d = seg_ext;
				end
			end else if (held_q < cfg.preroll_max) begin
				held_d  = held_q + HELD_W'(1);
				seg_out = seg_q;
				act     = ACT_HANG;
			end else begin
				act        = (seg_q >= cfg.segment_min) ? ACT_END : ACT_CANCEL;
				seg_out    = seg_q;
				seg_d      = '0;
				held_d     = '0;
				in_sound_d = 1'b0;
			end
		end

		res_d.action          = act;
		res_d.chunk_energy    = chunk.energy;
		res_d.chunk_crossings = chunk.crossings;
		res_d.segment_length  = seg_out;
		res_d.sound_active    = in_sound_d;
		res_d.preroll_count   = held_d;
	end

	assign pop = chunk_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sound_q  <= 1'b0;
			held_q      <= '0;
			seg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				in_sound_q <= in_sound_d;
				held_q     <= held_d;
				seg_q      <= seg_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = res_q;

	a_sound_has_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.sound_active |-> res_q.segment_length != '0)
		else $error("sound state reported with empty segment");

	a_silent_actions: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.action == ACT_CLEAR || res_q.action == ACT_ADD ||
		res_q.action == ACT_REPLACE) |-> res_q.segment_length == '0 && !res_q.sound_active)
		else $error("pre-roll action with segment data");

	a_end_actions: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.action == ACT_END || res_q.action == ACT_CANCEL ||
		res_q.action == ACT_END_MAX) |-> !res_q.sound_active && res_q.preroll_count == '0)
		else $error("segment end left sound state or held chunks");

	a_state_matches_output: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> in_sound_q == res_q.sound_active && held_q == res_q.preroll_count)
		else $error("state registers differ from reported result");

endmodule

FILE: rtl/energy_zcr_sound_segmenter_top.sv
// ----------------------------------------------------------------------------
// energy_zcr_sound_segmenter_top
// Dual-threshold energy / zero-crossing sound segmenter, one result per chunk.
// ----------------------------------------------------------------------------
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  first_sample, rest_peak
// m_axis    out        m_axis_tvalid/m_axis_tready  action .. preroll_count
// cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One frame per cycle is taken while intake is not stalled; the squaring
// multiplier is pipelined in two stages ahead of the energy accumulator.
// Each chunk result passes the squaring pipeline, queue and result register.
// A four-entry chunk queue decouples intake from the decision logic; intake
// stalls only when a chunk end meets a full queue.
// Reset clears the control state and loads the default register values.
// ----------------------------------------------------------------------------
module energy_zcr_sound_segmenter_top import ezss_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_CHUNK   = MAX_CHUNK_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// first_sample, rest_peak
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// action, chunk_energy, chunk_crossings, segment_length, sound_active,
	// preroll_count
	output logic [OUT_W-1:0]                       m_axis_tdata,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]                   cfg_index,
	input  logic [CFG_DATA_W-1:0]                  cfg_data
);

	cfg_t    cfg_q;
	logic    q_full;
	logic    q_push;
	chunk_t  q_push_data;
	logic    q_pop;
	logic    q_valid;
	chunk_t  q_head;
	result_t result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chunk_length   <= LEN_W'(480);
			cfg_q.energy_low     <= ENERGY_W'(1073742);
			cfg_q.energy_high    <= ENERGY_W'(10737418);
			cfg_q.crossings_low  <= CROSS_W'(144);
			cfg_q.crossings_high <= CROSS_W'(240);
			cfg_q.preroll_max    <= HELD_W'(5);
			cfg_q.segment_min    <= SEG_W'(20);
			cfg_q.segment_max    <= SEG_W'(480);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CHUNK_LENGTH:   cfg_q.chunk_length   <= cfg_data[LEN_W-1:0];
				REG_ENERGY_LOW:     cfg_q.energy_low     <= cfg_data[ENERGY_W-1:0];
				REG_ENERGY_HIGH:    cfg_q.energy_high    <= cfg_data[ENERGY_W-1:0];
				REG_CROSSINGS_LOW:  cfg_q.crossings_low  <= cfg_data[CROSS_W-1:0];
				REG_CROSSINGS_HIGH: cfg_q.crossings_high <= cfg_data[CROSS_W-1:0];
				REG_PREROLL_MAX:    cfg_q.preroll_max    <= cfg_data[HELD_W-1:0];
				REG_SEGMENT_MIN:    cfg_q.segment_min    <= cfg_data[SEG_W-1:0];
				REG_SEGMENT_MAX:    cfg_q.segment_max    <= cfg_data[SEG_W-1:0];
				default: ;
			endcase
		end
	end

	ezss_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_CHUNK  (MAX_CHUNK)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.first_sample(s_axis_tdata[SAMPLE_BITS-1:0]),
		.rest_peak   (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.chunk_length(cfg_q.chunk_length),
		.queue_full  (q_full),
		.push        (q_push),
		.push_data   (q_push_data)
	);

	ezss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head      (q_head)
	);

	ezss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.chunk_valid(q_valid),
		.chunk      (q_head),
		.pop        (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.result     (result)
	);

	assign m_axis_tdata = OUT_W'(result);

endmodule
